// ===== design/ptg_pkg.sv =====
// shared types, constants and helper functions for the pyramid triangle generator
// no dependencies
package ptg_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int CW = COORD_WIDTH;
  localparam int IN_W = ((6 * CW + 7) / 8) * 8;
  localparam int OUT_W = ((3 * CW + 48 + 7) / 8) * 8;
  localparam int NRM_W = 16;
  localparam logic [14:0] ONE_Q14 = 15'd16384;
  localparam logic [2:0] LAST_TRI = 3'd5;
  localparam logic [1:0] LAST_CORNER = 2'd2;

  // point indexes: corners 1..4 of the base, then the apex
  typedef enum logic [2:0] {
    PT_C1 = 3'd0,
    PT_C2 = 3'd1,
    PT_C3 = 3'd2,
    PT_C4 = 3'd3,
    PT_APEX = 3'd4
  } pt_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } pt_t;

  typedef struct packed {
    pt_t        pos;
    logic [2:0] tri_idx;
    logic [1:0] corner;
    logic       last;
  } vtx_t;

  // one vertex as it leaves the front end
  typedef struct packed {
    logic valid;
    vtx_t vtx;
    pt_t  p0;
    pt_t  p1;
    pt_t  p2;
  } issue_t;

  typedef struct packed {
    vtx_t       vtx;
    logic [2:0] sgn;
    logic       zero;
  } base_t;

  typedef struct packed {
    logic                    valid;
    vtx_t                    vtx;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
  } result_t;

  function automatic logic signed [CW-1:0] sat_add(logic signed [CW-1:0] a,
                                                    logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s[CW] != s[CW-1]) begin
      return s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    return s[CW-1:0];
  endfunction

  // corner order of each triangle; negative rise swaps positions one and two
  function automatic pt_idx_t corner_idx(logic [2:0] tri_idx, logic [1:0] pos, logic flip);
    logic [1:0] p;
    p = pos;
    if (flip && pos == 2'd1) p = 2'd2;
    else if (flip && pos == 2'd2) p = 2'd1;
    unique case (tri_idx)
      3'd0, 3'd1: begin
        // the second base triangle takes the first one's normal, so the
        // normal path sees triangle zero here; the vertex path overrides
        unique case (p)
          2'd0: return PT_C1;
          2'd1: return PT_C4;
          default: return PT_C2;
        endcase
      end
      3'd2: begin
        unique case (p)
          2'd0: return PT_APEX;
          2'd1: return PT_C1;
          default: return PT_C2;
        endcase
      end
      3'd3: begin
        unique case (p)
          2'd0: return PT_APEX;
          2'd1: return PT_C2;
          default: return PT_C3;
        endcase
      end
      3'd4: begin
        unique case (p)
          2'd0: return PT_APEX;
          2'd1: return PT_C3;
          default: return PT_C4;
        endcase
      end
      default: begin
        unique case (p)
          2'd0: return PT_APEX;
          2'd1: return PT_C4;
          default: return PT_C1;
        endcase
      end
    endcase
  endfunction

  function automatic pt_idx_t base2_idx(logic [1:0] pos, logic flip);
    logic [1:0] p;
    p = pos;
    if (flip && pos == 2'd1) p = 2'd2;
    else if (flip && pos == 2'd2) p = 2'd1;
    unique case (p)
      2'd0: return PT_C3;
      2'd1: return PT_C2;
      default: return PT_C4;
    endcase
  endfunction

endpackage

// ===== design/pyramid_triangle_generator.sv =====
// pyramid triangle generator top level: stream ports, front end and normal pipeline
// depends on ptg_pkg, ptg_front and ptg_normal
//
// usage:
//   s_axis carries one pyramid per transaction: origin, base extent and rise.
//   m_axis returns 18 vertices per pyramid, one per transaction, in triangle
//   order; tlast marks the eighteenth vertex.
//   throughput: one vertex per cycle while m_axis_tready stays high; the single
//   output channel sets that rate. the next pyramid is taken in the cycle
//   its predecessor issues its last vertex, so runs of pyramids stream with
//   no gap.
//   path: each vertex passes the front end, the edge, shift, cross product,
//   magnitude, scaling and squaring stages, the sum of squares, a 31-stage
//   square root, the divider setup, a 15-stage divider and the output register.
//   stall: while m_axis_tvalid is high and m_axis_tready is low the whole
//   pipeline holds, nothing is dropped or repeated, and s_axis_tready falls
//   once the front end is busy.
//   reset: synchronous, clears every valid bit; no clearing pass is needed.
module pyramid_triangle_generator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // origin_x, origin_y, origin_z, extent_x, extent_y, rise
  input  logic [ptg_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // vertex_x, vertex_y, vertex_z, unit_nx, unit_ny, unit_nz
  output logic [ptg_pkg::OUT_W-1:0]  m_axis_tdata,
  // triangle_number, corner_number
  output logic [4:0]                 m_axis_tuser,
  output logic                       m_axis_tlast
);
  import ptg_pkg::*;

  logic    en;
  issue_t  issue;
  result_t result;

  assign en = !result.valid || m_axis_tready;

  ptg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .issue    (issue)
  );

  ptg_normal u_normal (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .issue  (issue),
    .result (result)
  );

  assign m_axis_tvalid = result.valid;
  assign m_axis_tdata = OUT_W'({result.nz, result.ny, result.nx,
                                result.vtx.pos.z, result.vtx.pos.y, result.vtx.pos.x});
  assign m_axis_tuser = {result.vtx.corner, result.vtx.tri_idx};
  assign m_axis_tlast = result.vtx.last;

`ifndef SYNTHESIS
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == {LAST_CORNER, LAST_TRI})
    else $error("last vertex not at end of last triangle");

  a_base_normal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (result.vtx.tri_idx == 3'd0 || result.vtx.tri_idx == 3'd1)
      |-> result.nx == '0 && result.ny == '0)
    else $error("base normal not along z");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> result.nx <= 16'sd16384 && result.nx >= -16'sd16384
      && result.nz <= 16'sd16384 && result.nz >= -16'sd16384)
    else $error("normal component out of range");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> issue.valid && issue.vtx.tri_idx == 3'd0
      && issue.vtx.corner == 2'd0)
    else $error("new pyramid did not start at first vertex");
`endif

endmodule

// ===== design/ptg_front.sv =====
// front end: takes an input transaction, builds the five points and
// issues the 18 vertices one per cycle while en is high; uses ptg_pkg
module ptg_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ptg_pkg::IN_W-1:0] in_data,
  output ptg_pkg::issue_t       issue
);
  import ptg_pkg::*;

  logic       busy;
  logic [2:0] tri_idx;
  logic [1:0] corner;
  logic       flip;
  pt_t        c1, c2, c3, c4, apex;
  logic       last;
  logic       accept;
  logic signed [CW-1:0] ox, oy, oz, ex, ey, rz;
  logic signed [CW-1:0] xb, yb;

  assign ox = in_data[CW-1:0];
  assign oy = in_data[2*CW-1:CW];
  assign oz = in_data[3*CW-1:2*CW];
  assign ex = in_data[4*CW-1:3*CW];
  assign ey = in_data[5*CW-1:4*CW];
  assign rz = in_data[6*CW-1:5*CW];
  assign xb = sat_add(ox, ex);
  assign yb = sat_add(oy, ey);

  assign last = (tri_idx == LAST_TRI) && (corner == LAST_CORNER);
  assign in_ready = !busy || (en && last);
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      tri_idx <= '0;
      corner <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      tri_idx <= '0;
      corner <= '0;
    end else if (en && busy) begin
      if (last) begin
        busy <= 1'b0;
      end
      if (corner == LAST_CORNER) begin
        corner <= '0;
        tri_idx <= tri_idx + 3'd1;
      end else begin
        corner <= corner + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flip <= rz[CW-1];
      c1 <= '{x: ox, y: oy, z: oz};
      c2 <= '{x: xb, y: oy, z: oz};
      c3 <= '{x: xb, y: yb, z: oz};
      c4 <= '{x: ox, y: yb, z: oz};
      apex <= '{x: sat_add(ox, ex >>> 1), y: sat_add(oy, ey >>> 1), z: sat_add(oz, rz)};
    end
  end

  function automatic pt_t pick(pt_idx_t i, pt_t a, pt_t b, pt_t c, pt_t d, pt_t e);
    unique case (i)
      PT_C1: return a;
      PT_C2: return b;
      PT_C3: return c;
      PT_C4: return d;
      default: return e;
    endcase
  endfunction

  always_comb begin
    issue.valid = busy;
    issue.vtx.tri_idx = tri_idx;
    issue.vtx.corner = corner;
    issue.vtx.last = last;
    if (tri_idx == 3'd1) begin
      issue.vtx.pos = pick(base2_idx(corner, flip), c1, c2, c3, c4, apex);
    end else begin
      issue.vtx.pos = pick(corner_idx(tri_idx, corner, flip), c1, c2, c3, c4, apex);
    end
    issue.p0 = pick(corner_idx(tri_idx, 2'd0, flip), c1, c2, c3, c4, apex);
    issue.p1 = pick(corner_idx(tri_idx, 2'd1, flip), c1, c2, c3, c4, apex);
    issue.p2 = pick(corner_idx(tri_idx, 2'd2, flip), c1, c2, c3, c4, apex);
  end

endmodule

// ===== design/ptg_normal.sv =====
// unit normal pipeline: edges, cross product, normalize, square root and
// division, one vertex per stage per cycle while en is high; uses ptg_pkg
module ptg_normal (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ptg_pkg::issue_t  issue,
  output ptg_pkg::result_t result
);
  import ptg_pkg::*;

  typedef struct {
    logic  v;
    base_t b;
    logic signed [63:0] e1 [3];
    logic signed [63:0] e2 [3];
  } sa_t;
  typedef struct {
    logic  v;
    base_t b;
    logic signed [31:0] e1 [3];
    logic signed [31:0] e2 [3];
  } sb_t;
  typedef struct {
    logic  v;
    base_t b;
    logic signed [63:0] p [6];
  } sc_t;
  typedef struct {
    logic  v;
    base_t b;
    logic signed [63:0] c [3];
  } sd_t;
  typedef struct {
    logic  v;
    base_t b;
    logic [63:0] m [3];
    logic [63:0] orv;
  } se_t;
  typedef struct {
    logic  v;
    base_t b;
    logic [63:0] m [3];
    logic [5:0]  lead;
  } sf_t;
  typedef struct {
    logic  v;
    base_t b;
    logic [29:0] mg [3];
  } sg_t;
  typedef struct {
    logic  v;
    base_t b;
    logic [29:0] mg [3];
    logic [59:0] sq [3];
  } sh_t;
  typedef struct {
    logic  v;
    base_t b;
    logic [29:0] mg [3];
    logic [62:0] n;
    logic [62:0] r;
  } sq_t;
  typedef struct {
    logic  v;
    base_t b;
    logic [46:0] rem [3];
    logic [31:0] d;
    logic [14:0] q [3];
  } dv_t;

  localparam int SQ_STEPS = 31;
  localparam int DV_STEPS = 15;

  sa_t sa, sa_next;
  sb_t sb, sb_next;
  sc_t sc, sc_next;
  sd_t sd, sd_next;
  se_t se, se_next;
  sf_t sf, sf_next;
  sg_t sg, sg_next;
  sh_t sh, sh_next;
  sq_t sqs [SQ_STEPS+1];
  dv_t dvs [DV_STEPS+1];
  result_t res_next;

  function automatic logic signed [63:0] widen(logic signed [CW-1:0] a);
    return 64'(a);
  endfunction

  // edges
  always_comb begin
    pt_t p [3];
    p[0] = issue.p0;
    p[1] = issue.p1;
    p[2] = issue.p2;
    sa_next.v = issue.valid;
    sa_next.b.vtx = issue.vtx;
    sa_next.b.sgn = '0;
    sa_next.b.zero = 1'b0;
    sa_next.e1[0] = widen(p[1].x) - widen(p[0].x);
    sa_next.e1[1] = widen(p[1].y) - widen(p[0].y);
    sa_next.e1[2] = widen(p[1].z) - widen(p[0].z);
    sa_next.e2[0] = widen(p[2].x) - widen(p[0].x);
    sa_next.e2[1] = widen(p[2].y) - widen(p[0].y);
    sa_next.e2[2] = widen(p[2].z) - widen(p[0].z);
  end

  // common shift so every edge fits 32 bits signed, toward zero
  always_comb begin
    logic [63:0] orv;
    logic [1:0]  s;
    logic [63:0] mag;
    orv = '0;
    for (int k = 0; k < 3; k++) begin
      orv = orv | (sa.e1[k][63] ? 64'(-sa.e1[k]) : 64'(sa.e1[k]));
      orv = orv | (sa.e2[k][63] ? 64'(-sa.e2[k]) : 64'(sa.e2[k]));
    end
    if ((orv >> 31) == 64'd0) s = 2'd0;
    else if ((orv >> 32) == 64'd0) s = 2'd1;
    else s = 2'd2;
    sb_next.v = sa.v;
    sb_next.b = sa.b;
    for (int k = 0; k < 3; k++) begin
      mag = sa.e1[k][63] ? 64'(-sa.e1[k]) : 64'(sa.e1[k]);
      mag = mag >> s;
      sb_next.e1[k] = sa.e1[k][63] ? 32'(-mag) : mag[31:0];
      mag = sa.e2[k][63] ? 64'(-sa.e2[k]) : 64'(sa.e2[k]);
      mag = mag >> s;
      sb_next.e2[k] = sa.e2[k][63] ? 32'(-mag) : mag[31:0];
    end
  end

  // cross product partial products
  always_comb begin
    sc_next.v = sb.v;
    sc_next.b = sb.b;
    sc_next.p[0] = 64'(sb.e1[1]) * 64'(sb.e2[2]);
    sc_next.p[1] = 64'(sb.e1[2]) * 64'(sb.e2[1]);
    sc_next.p[2] = 64'(sb.e1[2]) * 64'(sb.e2[0]);
    sc_next.p[3] = 64'(sb.e1[0]) * 64'(sb.e2[2]);
    sc_next.p[4] = 64'(sb.e1[0]) * 64'(sb.e2[1]);
    sc_next.p[5] = 64'(sb.e1[1]) * 64'(sb.e2[0]);
  end

  always_comb begin
    sd_next.v = sc.v;
    sd_next.b = sc.b;
    for (int k = 0; k < 3; k++) begin
      sd_next.c[k] = sc.p[2*k] - sc.p[2*k+1];
    end
  end

  // magnitudes and signs; the or of the magnitudes has the max's leading bit
  always_comb begin
    se_next.v = sd.v;
    se_next.b = sd.b;
    se_next.orv = '0;
    for (int k = 0; k < 3; k++) begin
      se_next.b.sgn[k] = sd.c[k][63];
      se_next.m[k] = sd.c[k][63] ? 64'(-sd.c[k]) : 64'(sd.c[k]);
      se_next.orv = se_next.orv | se_next.m[k];
    end
  end

  always_comb begin
    sf_next.v = se.v;
    sf_next.b = se.b;
    sf_next.b.zero = (se.orv == 64'd0);
    sf_next.m = se.m;
    sf_next.lead = '0;
    for (int i = 0; i < 64; i++) begin
      if (se.orv[i]) sf_next.lead = 6'(i);
    end
  end

  // scale so the largest magnitude lies in [2^29, 2^30)
  always_comb begin
    logic [63:0] t;
    sg_next.v = sf.v;
    sg_next.b = sf.b;
    for (int k = 0; k < 3; k++) begin
      if (sf.lead >= 6'd29) t = sf.m[k] >> (sf.lead - 6'd29);
      else t = sf.m[k] << (6'd29 - sf.lead);
      sg_next.mg[k] = t[29:0];
    end
  end

  always_comb begin
    sh_next.v = sg.v;
    sh_next.b = sg.b;
    sh_next.mg = sg.mg;
    for (int k = 0; k < 3; k++) begin
      sh_next.sq[k] = 60'(sg.mg[k]) * 60'(sg.mg[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.v <= 1'b0;
      sb.v <= 1'b0;
      sc.v <= 1'b0;
      sd.v <= 1'b0;
      se.v <= 1'b0;
      sf.v <= 1'b0;
      sg.v <= 1'b0;
      sh.v <= 1'b0;
      sqs[0].v <= 1'b0;
    end else if (en) begin
      sa <= sa_next;
      sb <= sb_next;
      sc <= sc_next;
      sd <= sd_next;
      se <= se_next;
      sf <= sf_next;
      sg <= sg_next;
      sh <= sh_next;
      sqs[0].v <= sh.v;
      sqs[0].b <= sh.b;
      sqs[0].mg <= sh.mg;
      sqs[0].n <= 63'(sh.sq[0]) + 63'(sh.sq[1]) + 63'(sh.sq[2]);
      sqs[0].r <= '0;
    end
  end

  // floor square root, one result bit per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [62:0] BIT = 63'(1) << (2 * (SQ_STEPS - 1 - k));
    always_ff @(posedge clk) begin
      if (rst) begin
        sqs[k+1].v <= 1'b0;
      end else if (en) begin
        sqs[k+1].v <= sqs[k].v;
        sqs[k+1].b <= sqs[k].b;
        sqs[k+1].mg <= sqs[k].mg;
        if (sqs[k].n >= sqs[k].r + BIT) begin
          sqs[k+1].n <= sqs[k].n - (sqs[k].r + BIT);
          sqs[k+1].r <= (sqs[k].r >> 1) + BIT;
        end else begin
          sqs[k+1].n <= sqs[k].n;
          sqs[k+1].r <= sqs[k].r >> 1;
        end
      end
    end
  end

  // rounded quotient (mg*32768 + len) / (2*len)
  always_ff @(posedge clk) begin
    if (rst) begin
      dvs[0].v <= 1'b0;
    end else if (en) begin
      dvs[0].v <= sqs[SQ_STEPS].v;
      dvs[0].b <= sqs[SQ_STEPS].b;
      dvs[0].d <= {sqs[SQ_STEPS].r[30:0], 1'b0};
      for (int k = 0; k < 3; k++) begin
        dvs[0].rem[k] <= {2'b0, sqs[SQ_STEPS].mg[k], 15'b0} + 47'(sqs[SQ_STEPS].r[30:0]);
        dvs[0].q[k] <= '0;
      end
    end
  end

  for (genvar j = 0; j < DV_STEPS; j++) begin : g_div
    localparam int SH = DV_STEPS - 1 - j;
    logic [46:0] dsh;
    assign dsh = 47'(dvs[j].d) << SH;
    always_ff @(posedge clk) begin
      if (rst) begin
        dvs[j+1].v <= 1'b0;
      end else if (en) begin
        dvs[j+1].v <= dvs[j].v;
        dvs[j+1].b <= dvs[j].b;
        dvs[j+1].d <= dvs[j].d;
        for (int k = 0; k < 3; k++) begin
          if (dvs[j].rem[k] >= dsh) begin
            dvs[j+1].rem[k] <= dvs[j].rem[k] - dsh;
            dvs[j+1].q[k] <= dvs[j].q[k] | (15'd1 << SH);
          end else begin
            dvs[j+1].rem[k] <= dvs[j].rem[k];
            dvs[j+1].q[k] <= dvs[j].q[k];
          end
        end
      end
    end
  end

  always_comb begin
    logic [14:0] u [3];
    logic signed [NRM_W-1:0] n [3];
    for (int k = 0; k < 3; k++) begin
      u[k] = (dvs[DV_STEPS].q[k] > ONE_Q14) ? ONE_Q14 : dvs[DV_STEPS].q[k];
      if (dvs[DV_STEPS].b.zero) n[k] = '0;
      else if (dvs[DV_STEPS].b.sgn[k]) n[k] = -$signed({1'b0, u[k]});
      else n[k] = $signed({1'b0, u[k]});
    end
    res_next.valid = dvs[DV_STEPS].v;
    res_next.vtx = dvs[DV_STEPS].b.vtx;
    res_next.nx = n[0];
    res_next.ny = n[1];
    res_next.nz = n[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result <= res_next;
    end
  end

endmodule

// ===== verif/tb.sv =====
// testbench for the pyramid triangle generator: directed and random pyramids,
// each of the 18 vertices checked against a behavioral model held here
// depends on ptg_pkg and pyramid_triangle_generator
module tb;
  import ptg_pkg::*;

  localparam int LAT = 80;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
    logic signed [15:0]   nx, ny, nz;
    logic [2:0]           tri_n;
    logic [1:0]           corner_n;
    logic                 last;
  } vertex_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [4:0] m_axis_tuser;
  logic m_axis_tlast;

  int send_idle = 0;
  int recv_idle = 0;
  int mismatches = 0;
  vertex_t vertex_queue[$];

  pyramid_triangle_generator dut (.*);

  always #6 clk = ~clk;

  function automatic longint sat_c(longint v);
    longint hi;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint isqrt(longint n);
    longint r, b;
    r = 0;
    b = longint'(1) <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // unit normal of (p1-p0)x(p2-p0) in q1.14
  task automatic face_normal(input longint p0[3], input longint p1[3], input longint p2[3],
                             output longint nrm[3]);
    longint e1[3], e2[3], c[3], mg[3], m, sum, len, u;
    int s;
    m = 0;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      e1[k] = p1[k] - p0[k];
      e2[k] = p2[k] - p0[k];
      if (mag(e1[k]) > m) m = mag(e1[k]);
      if (mag(e2[k]) > m) m = mag(e2[k]);
    end
    while ((m >>> s) >= (longint'(1) <<< 31)) s++;
    for (int k = 0; k < 3; k++) begin
      e1[k] = e1[k] < 0 ? -(mag(e1[k]) >>> s) : e1[k] >>> s;
      e2[k] = e2[k] < 0 ? -(mag(e2[k]) >>> s) : e2[k] >>> s;
    end
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    m = 0;
    for (int k = 0; k < 3; k++) begin
      mg[k] = mag(c[k]);
      if (mg[k] > m) m = mg[k];
    end
    if (m == 0) begin
      nrm = '{0, 0, 0};
      return;
    end
    while (m >= (longint'(1) <<< 30)) begin
      m = m >>> 1;
      for (int k = 0; k < 3; k++) mg[k] = mg[k] >>> 1;
    end
    while (m < (longint'(1) <<< 29)) begin
      m = m <<< 1;
      for (int k = 0; k < 3; k++) mg[k] = mg[k] <<< 1;
    end
    // sum of squares stays below 2^62, fits signed 64
    sum = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
    len = isqrt(sum);
    for (int k = 0; k < 3; k++) begin
      u = (mg[k] * 32768 + len) / (2 * len);
      if (u > 16384) u = 16384;
      nrm[k] = c[k] < 0 ? -u : u;
    end
  endtask

  task automatic predict_vertices(input logic signed [CW-1:0] f[6]);
    longint ox, oy, oz, ex, ey, rz, xb, yb;
    longint pts[5][3];
    longint nrm[3];
    pt_idx_t order[6][3];
    int idx[3];
    bit flip;
    vertex_t v;
    ox = f[0]; oy = f[1]; oz = f[2]; ex = f[3]; ey = f[4]; rz = f[5];
    flip = rz < 0;
    order = '{'{PT_C1, PT_C4, PT_C2}, '{PT_C3, PT_C2, PT_C4}, '{PT_APEX, PT_C1, PT_C2},
              '{PT_APEX, PT_C2, PT_C3}, '{PT_APEX, PT_C3, PT_C4}, '{PT_APEX, PT_C4, PT_C1}};
    xb = sat_c(ox + ex);
    yb = sat_c(oy + ey);
    pts[0] = '{ox, oy, oz};
    pts[1] = '{xb, oy, oz};
    pts[2] = '{xb, yb, oz};
    pts[3] = '{ox, yb, oz};
    // half extent rounds toward minus infinity
    pts[4] = '{sat_c(ox + (ex >>> 1)), sat_c(oy + (ey >>> 1)), sat_c(oz + rz)};
    nrm = '{0, 0, 0};
    for (int t = 0; t < 6; t++) begin
      idx[0] = order[t][0];
      idx[1] = order[t][flip ? 2 : 1];
      idx[2] = order[t][flip ? 1 : 2];
      if (t != 1) face_normal(pts[idx[0]], pts[idx[1]], pts[idx[2]], nrm);
      for (int c = 0; c < 3; c++) begin
        v.x = CW'(pts[idx[c]][0]);
        v.y = CW'(pts[idx[c]][1]);
        v.z = CW'(pts[idx[c]][2]);
        v.nx = 16'(nrm[0]);
        v.ny = 16'(nrm[1]);
        v.nz = 16'(nrm[2]);
        v.tri_n = 3'(t);
        v.corner_n = 2'(c);
        v.last = (t == 5 && c == 2);
        vertex_queue.push_back(v);
      end
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic send_pyramid(input logic signed [CW-1:0] f[6]);
    logic [IN_W-1:0] d;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    d = '0;
    for (int k = 0; k < 6; k++) d[k*CW +: CW] = f[k];
    predict_vertices(f);
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_fields(input longint a, input longint b, input longint c,
                             input longint d, input longint e, input longint r);
    logic signed [CW-1:0] f[6];
    f = '{CW'(a), CW'(b), CW'(c), CW'(d), CW'(e), CW'(r)};
    send_pyramid(f);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return CW'($urandom);
      1: return CW'($signed(CW'($urandom_range(8191))) - 4096);
      default: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
    endcase
  endfunction

  task automatic drain();
    int n;
    n = 0;
    s_axis_tvalid <= 0;
    while (vertex_queue.size() != 0) @(posedge clk);
    while (n < LAT) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic test_directed();
    longint mx, mn;
    mx = (longint'(1) <<< (CW - 1)) - 1;
    mn = -mx - 1;
    send_fields(0, 0, 0, 4096, 4096, 4096);
    send_fields(0, 0, 0, 4096, 4096, -4096);
    send_fields(100, 200, 300, 8192, 4096, 0);
    send_fields(0, 0, 0, 0, 0, 0);
    send_fields(0, 0, 0, 0, 4096, 4096);
    send_fields(mx, mx, mx, mx, mx, mx);
    send_fields(mn, mn, mn, mn, mn, mn);
    send_fields(mx, mn, mx, mn, mx, mn);
    send_fields(mn, mx, mn, mx, mn, mx);
    send_fields(0, 0, mx, 4096, 4096, 4096);
    send_fields(0, 0, mn, 4096, 4096, -4096);
    send_fields(-1, -1, -1, -1, -1, -1);
    send_fields(5, 7, 0, -3, -5, 1);
    send_fields(mx, 0, 0, 4096, 4096, 100);
    send_fields(0, 0, 0, -4096, 8192, mx);
    send_fields(0, 0, 0, mx, 1, mn);
    send_fields(0, -1, 0, 1, mn, 1);
    drain();
  endtask

  task automatic test_random(input int count, input int s_idle, input int r_idle);
    logic signed [CW-1:0] f[6];
    int mode;
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(9);
      for (int k = 0; k < 6; k++)
        f[k] = rand_coord(mode < 5 ? 0 : mode < 9 ? 1 : $urandom_range(2));
      send_pyramid(f);
    end
    drain();
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    m_axis_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    vertex_t w;
    logic signed [CW-1:0] gx, gy, gz;
    logic signed [15:0] gnx, gny, gnz;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (vertex_queue.size() == 0) begin
        $display("mismatch: vertex with none expected");
        mismatches++;
      end else begin
        w = vertex_queue.pop_front();
        gx = m_axis_tdata[0 +: CW];
        gy = m_axis_tdata[CW +: CW];
        gz = m_axis_tdata[2*CW +: CW];
        gnx = m_axis_tdata[3*CW +: 16];
        gny = m_axis_tdata[3*CW+16 +: 16];
        gnz = m_axis_tdata[3*CW+32 +: 16];
        if (gx != w.x) report("vertex_x", gx, w.x);
        if (gy != w.y) report("vertex_y", gy, w.y);
        if (gz != w.z) report("vertex_z", gz, w.z);
        if (gnx != w.nx) report("unit_nx", gnx, w.nx);
        if (gny != w.ny) report("unit_ny", gny, w.ny);
        if (gnz != w.nz) report("unit_nz", gnz, w.nz);
        if (m_axis_tuser[2:0] != w.tri_n) report("triangle_number", m_axis_tuser[2:0], w.tri_n);
        if (m_axis_tuser[4:3] != w.corner_n)
          report("corner_number", m_axis_tuser[4:3], w.corner_n);
        if (m_axis_tlast != w.last) report("final_vertex", m_axis_tlast, w.last);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(110, 28, 79);
    test_random(110, 79, 28);
    test_random(110, 0, 0);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
design/ptg_pkg.sv
design/ptg_front.sv
design/ptg_normal.sv
design/pyramid_triangle_generator.sv
verif/tb.sv
